@@ hdl/pla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light accumulate package
// Shared types and constants for the point light accumulate unit.
// ----------------------------------------------------------------------------
package pla_pkg;

	localparam int REQ_WRITE = 0;
	localparam int REQ_SHADE = 1;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic               req_type;
		logic [6:0]         slot;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         strength;
		logic               present;
	} pla_in_t;

	typedef struct packed {
		logic [7:0] lit_red;
		logic [7:0] lit_green;
		logic [7:0] lit_blue;
	} pla_out_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIST,
		ST_DIV,
		ST_MAC,
		ST_DONE
	} pla_state_t;

	// Divider handshake.
	typedef struct packed {
		logic go;
	} pla_div_ctl_t;

endpackage

@@ hdl/pla_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/pla_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider: one quotient bit a cycle, quotient clamped to ONE_Q16 (1.0).
// ----------------------------------------------------------------------------
module pla_div
	import pla_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  pla_div_ctl_t ctl,
	input  logic [34:0]  numer,
	input  logic [34:0]  denom,
	output logic         done,
	output logic [16:0]  quot
);

	logic [34:0] rem_q;
	logic [34:0] num_q;
	logic [34:0] quo_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [35:0] trial;

	assign trial = {rem_q, num_q[34]} - {1'b0, denom};

	// One quotient bit per cycle, MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd35;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (ctl.go) begin
			rem_q <= '0;
			num_q <= numer;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[33:0], 1'b0};
			if (!trial[35]) begin
				rem_q <= trial[34:0];
				quo_q <= {quo_q[33:0], 1'b1};
			end else begin
				rem_q <= {rem_q[33:0], num_q[34]};
				quo_q <= {quo_q[33:0], 1'b0};
			end
		end
	end

	assign quot = (quo_q > 35'(ONE_Q16)) ? ONE_Q16 : quo_q[16:0];

endmodule

@@ hdl/pla_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shade engine
// Walks the light table, forms distance, intensity and the channel sums.
// ----------------------------------------------------------------------------
module pla_engine
	import pla_pkg::*;
#(
	parameter int MAX_LIGHTS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  pla_in_t     req,
	input  logic [6:0]  lights_in_use,
	input  logic [47:0] pos_rd,
	input  logic [32:0] prop_rd,
	input  logic        prop_valid,
	output logic [6:0]  rd_addr,
	output logic        done,
	output pla_out_t    res
);

	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

	pla_state_t  state_q, state_d;
	logic [7:0]  idx_q;
	logic [7:0]  cnt_q;
	logic [1:0]  ax_q;
	logic [34:0] dist_q;
	logic [16:0] inten_q;
	logic [24:0] acc_r_q, acc_g_q, acc_b_q;
	logic signed [15:0] qx_q, qy_q, qz_q;
	logic [47:0] pos_q;
	logic [32:0] prop_q;
	logic        pv_q;
	logic [16:0] diff;
	logic signed [16:0] sd;
	logic [33:0] sq;
	logic        div_done;
	logic [16:0] quot;
	pla_div_ctl_t dctl;
	logic [7:0]  limit;
	logic [7:0]  n_lim;
	logic [15:0] comp;

	assign n_lim = (lights_in_use == 7'd0) ? 8'd0 : 8'(lights_in_use) - 8'd1;
	assign limit = (n_lim > 8'(MAX_LIGHTS)) ? 8'(MAX_LIGHTS) : n_lim;

	// One axis a cycle: difference and square.
	always_comb begin
		case (ax_q)
			2'd0:    comp = pos_q[47:32];
			2'd1:    comp = pos_q[31:16];
			default: comp = pos_q[15:0];
		endcase
		case (ax_q)
			2'd0:    sd = 17'(signed'(comp)) - 17'(qx_q);
			2'd1:    sd = 17'(signed'(comp)) - 17'(qy_q);
			default: sd = 17'(signed'(comp)) - 17'(qz_q);
		endcase
		diff = sd[16] ? 17'(-sd) : 17'(sd);
		sq   = 34'(diff) * 34'(diff);
	end

	assign rd_addr = 7'(idx_q[AW-1:0]);

	pla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.numer  ({prop_q[8:1], 27'd0}),
		.denom  (dist_q),
		.done   (div_done),
		.quot   (quot)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		dctl.go = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go) state_d = ST_READ;
			end
			ST_READ: begin
				if (idx_q >= limit) state_d = ST_DONE;
				else if (cnt_q == 8'd1) state_d = ST_DIST;
			end
			ST_DIST: begin
				if (!(pv_q && prop_q[0])) state_d = ST_READ;
				else if (ax_q == 2'd2) begin
					if (dist_q + 35'(sq) != 35'd0) begin
						state_d = ST_DIV;
						dctl.go = 1'b1;
					end else begin
						state_d = ST_MAC;
					end
				end
			end
			ST_DIV: begin
				if (div_done) state_d = ST_MAC;
			end
			ST_MAC: state_d = ST_READ;
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q   <= '0;
				cnt_q   <= '0;
				qx_q    <= req.pos_x;
				qy_q    <= req.pos_y;
				qz_q    <= req.pos_z;
				acc_r_q <= {1'b0, req.red, 16'd0};
				acc_g_q <= {1'b0, req.green, 16'd0};
				acc_b_q <= {1'b0, req.blue, 16'd0};
			end
			ST_READ: begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'd1) begin
					pos_q  <= pos_rd;
					prop_q <= prop_rd;
					pv_q   <= prop_valid;
					ax_q   <= 2'd0;
					dist_q <= '0;
					inten_q <= ONE_Q16;
				end
			end
			ST_DIST: begin
				dist_q <= dist_q + 35'(sq);
				ax_q   <= ax_q + 2'd1;
				cnt_q  <= '0;
				if (!(pv_q && prop_q[0])) idx_q <= idx_q + 8'd1;
			end
			ST_DIV: begin
				if (div_done) inten_q <= quot;
			end
			ST_MAC: begin
				// A channel that has passed 255 stays saturated.
				if (!acc_r_q[24]) acc_r_q <= acc_r_q + 25'(inten_q * prop_q[32:25]);
				if (!acc_g_q[24]) acc_g_q <= acc_g_q + 25'(inten_q * prop_q[24:17]);
				if (!acc_b_q[24]) acc_b_q <= acc_b_q + 25'(inten_q * prop_q[16:9]);
				idx_q   <= idx_q + 8'd1;
			end
			default: ;
		endcase
	end

	assign res.lit_red   = (acc_r_q[24]) ? 8'hFF : acc_r_q[23:16];
	assign res.lit_green = (acc_g_q[24]) ? 8'hFF : acc_g_q[23:16];
	assign res.lit_blue  = (acc_b_q[24]) ? 8'hFF : acc_b_q[23:16];

endmodule

@@ hdl/point_light_accumulate_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light accumulate unit
// Light table plus a shade engine that sums inverse-square light.
// ----------------------------------------------------------------------------
// A write beat keeps busy high for one cycle. A shade beat keeps busy high until
// the shade engine finishes; each present light at nonzero distance waits on the
// serial divider. The result appears for one cycle on done; the receiver cannot
// stall it. Presence bits are flip-flops cleared by reset.
module point_light_accumulate_unit
	import pla_pkg::*;
#(
	parameter int MAX_LIGHTS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pla_in_t     req,
	output logic        done,
	output pla_out_t    res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

	logic [6:0]  liu_q;
	logic        wr_q;
	logic        shade_q;
	pla_in_t     req_q;
	logic [MAX_LIGHTS-1:0] valid_q;
	logic [6:0]  rd_addr;
	logic [47:0] pos_rd;
	logic [32:0] prop_rd;
	logic        pv_q;
	logic        eng_done;
	logic        wen;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {25'd0, liu_q} : 32'd0;
	assign busy   = wr_q | shade_q;

	// Config register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q <= '0;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			liu_q <= pwdata[6:0];
		end
	end

	assign wen = wr_q && (32'(req_q.slot) < 32'(MAX_LIGHTS));

	// Request control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			shade_q <= 1'b0;
			valid_q <= '0;
		end else begin
			wr_q <= 1'b0;
			if (start && !busy) begin
				wr_q    <= (req.req_type == 1'(REQ_WRITE));
				shade_q <= (req.req_type == 1'(REQ_SHADE));
			end
			if (eng_done) shade_q <= 1'b0;
			if (wen) valid_q[req_q.slot[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= req;
		pv_q <= valid_q[rd_addr[AW-1:0]];
	end

	pla_ram #(.WIDTH(48), .DEPTH(MAX_LIGHTS)) u_pos (
		.clk   (clk),
		.we    (wen),
		.waddr (req_q.slot[AW-1:0]),
		.wdata ({req_q.pos_x, req_q.pos_y, req_q.pos_z}),
		.raddr (rd_addr[AW-1:0]),
		.rdata (pos_rd)
	);

	pla_ram #(.WIDTH(33), .DEPTH(MAX_LIGHTS)) u_prop (
		.clk   (clk),
		.we    (wen),
		.waddr (req_q.slot[AW-1:0]),
		.wdata ({req_q.red, req_q.green, req_q.blue, req_q.strength, req_q.present}),
		.raddr (rd_addr[AW-1:0]),
		.rdata (prop_rd)
	);

	pla_engine #(.MAX_LIGHTS(MAX_LIGHTS)) u_eng (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (shade_q && !wr_q && !eng_done),
		.req           (req_q),
		.lights_in_use (liu_q),
		.pos_rd        (pos_rd),
		.prop_rd       (prop_rd),
		.prop_valid    (pv_q),
		.rd_addr       (rd_addr),
		.done          (eng_done),
		.res           (res)
	);

	assign done = eng_done;

endmodule

@@ hdl/pla_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light accumulate checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module pla_port_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);

	// A result strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// A result only comes while busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	// An accepted beat makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept ignored");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind point_light_accumulate_unit pla_port_props u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);

@@ bench/pla_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light accumulate checker
// Watches the request, result and register ports of the unit, predicts each
// shaded color from its own copy of the light table and compares results.
// ----------------------------------------------------------------------------
module pla_checker
	import pla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  pla_in_t     req,
	input  logic        done,
	input  pla_out_t    res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	// Shadow light table and slot count register.
	logic signed [15:0] lx [128];
	logic signed [15:0] ly [128];
	logic signed [15:0] lz [128];
	logic [7:0]         lr [128];
	logic [7:0]         lg [128];
	logic [7:0]         lb [128];
	logic [7:0]         lstr [128];
	logic               lpres [128];
	logic [6:0]         slot_count;

	pla_out_t lit_colors [$];

	function automatic logic [63:0] sqd(logic signed [15:0] a, logic signed [15:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return d * d;
	endfunction

	function automatic logic [7:0] sat_q16(logic [63:0] acc);
		logic [63:0] v;
		v = acc >> 16;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Sum inverse-square light from the examined slots onto the base color.
	function automatic pla_out_t shade_color(pla_in_t q);
		logic [63:0] ar, ag, ab, d, inten;
		int n;
		pla_out_t o;
		ar = 64'(q.red) << 16;
		ag = 64'(q.green) << 16;
		ab = 64'(q.blue) << 16;
		n = (slot_count > 0) ? slot_count - 1 : 0;
		for (int i = 0; i < n; i++) begin
			if (lpres[i]) begin
				d = sqd(lx[i], q.pos_x) + sqd(ly[i], q.pos_y) + sqd(lz[i], q.pos_z);
				if (d == 0) begin
					inten = 64'(ONE_Q16);
				end else begin
					inten = (64'(lstr[i]) << 27) / d;
					if (inten > 64'(ONE_Q16))
						inten = 64'(ONE_Q16);
				end
				ar += inten * lr[i];
				ag += inten * lg[i];
				ab += inten * lb[i];
			end
		end
		o.lit_red = sat_q16(ar);
		o.lit_green = sat_q16(ag);
		o.lit_blue = sat_q16(ab);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pla_out_t e;
		if (!arst_n) begin
			for (int i = 0; i < 128; i++)
				lpres[i] = 1'b0;
			slot_count = '0;
			lit_colors.delete();
			fails = 0;
			pending = 0;
		end else begin
			// Compare a result beat with the oldest expected color.
			if (done) begin
				if (lit_colors.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, res);
					fails++;
				end else begin
					e = lit_colors.pop_front();
					if (res.lit_red !== e.lit_red || res.lit_green !== e.lit_green ||
					    res.lit_blue !== e.lit_blue) begin
						$display("%0t: color mismatch, expected %h, actual %h",
							$time, e, res);
						fails++;
					end
				end
			end
			// Register writes.
			if (psel && penable && pwrite && pready && paddr == 1'b0)
				slot_count = pwdata[6:0];
			// Accepted request beats.
			if (start && !busy) begin
				if (req.req_type == 1'(REQ_WRITE)) begin
					lx[req.slot] = req.pos_x;
					ly[req.slot] = req.pos_y;
					lz[req.slot] = req.pos_z;
					lr[req.slot] = req.red;
					lg[req.slot] = req.green;
					lb[req.slot] = req.blue;
					lstr[req.slot] = req.strength;
					lpres[req.slot] = req.present;
				end else begin
					lit_colors.push_back(shade_color(req));
				end
			end
			pending = lit_colors.size();
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light accumulate testbench
// Fills the light table, shades points under several slot counts with random
// gaps between beats, and lets the checker compare every shaded color.
// ----------------------------------------------------------------------------
module tb;
	import pla_pkg::*;

	localparam int LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pla_in_t     req = '0;
	logic        done;
	pla_out_t    res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic        paddr = 1'b0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fails;
	int          pending;
	int          cycles = 0;
	bit          quiet = 1'b0;

	always #5 clk = ~clk;

	point_light_accumulate_unit dut (.*);

	pla_checker chk (.*);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one request beat and wait for it to be taken.
	task automatic send(pla_in_t item);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		req = item;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Wait for all colors, let the engine settle, then set the slot count.
	task automatic set_count(logic [6:0] n);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = 1'b0;
		pwdata = {$urandom} & 32'hFFFF_FF80 | 32'(n);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic pla_in_t mk(int t, int s, int x, int y, int z,
		int r, int g, int b, int st, int p);
		pla_in_t q;
		q.req_type = 1'(t); q.slot = 7'(s);
		q.pos_x = 16'(x); q.pos_y = 16'(y); q.pos_z = 16'(z);
		q.red = 8'(r); q.green = 8'(g); q.blue = 8'(b); q.strength = 8'(st);
		q.present = 1'(p);
		return q;
	endfunction

	// Random beat: writes mostly go to low slots, positions are mostly nearby.
	function automatic pla_in_t rnd_item(int n);
		pla_in_t q;
		q = pla_in_t'({$urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(0, 4) != 0) begin
			q.pos_x = 16'($signed($urandom_range(0, 600)) - 300);
			q.pos_y = 16'($signed($urandom_range(0, 600)) - 300);
			q.pos_z = 16'($signed($urandom_range(0, 600)) - 300);
		end
		if (q.req_type == 1'(REQ_WRITE)) begin
			if ($urandom_range(0, 5) != 0)
				q.slot = 7'($urandom_range(0, (n > 1) ? n - 1 : 1));
			q.present = ($urandom_range(0, 4) != 0);
		end
		return q;
	endfunction

	logic [6:0] counts [7] = '{7'd4, 7'd0, 7'd1, 7'd127, 7'd126, 7'd9, 7'd33};

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, zero distance, absent slot, top slot.
		set_count(counts[0]);
		send(mk(REQ_WRITE, 0, 0, 0, 0, 255, 0, 128, 255, 1));
		send(mk(REQ_WRITE, 1, -32768, -32768, -32768, 10, 20, 30, 0, 1));
		send(mk(REQ_WRITE, 2, 32767, 32767, 32767, 255, 255, 255, 255, 0));
		send(mk(REQ_WRITE, 3, 100, 0, 0, 200, 200, 200, 1, 1));
		send(mk(REQ_WRITE, 127, 32767, -1, 1, 1, 2, 3, 128, 1));
		send(mk(REQ_SHADE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(REQ_SHADE, 127, 32767, 32767, 32767, 255, 255, 255, 255, 1));
		send(mk(REQ_SHADE, 5, -32768, -32768, -32768, 1, 2, 3, 7, 0));
		send(mk(REQ_SHADE, 64, 100, 5, -5, 40, 0, 250, 0, 1));
		send(mk(REQ_SHADE, 1, 32767, -32768, 0, 0, 255, 0, 0, 0));
		send(mk(REQ_SHADE, 0, 1, 0, 0, 0, 0, 0, 0, 0));

		// Random phases over several slot counts; the last has no gaps.
		for (int ph = 0; ph < 7; ph++) begin
			if (ph != 0)
				set_count(counts[ph]);
			quiet = (ph == 6);
			repeat (19) send(rnd_item(counts[ph]));
		end

		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/pla_pkg.sv
hdl/pla_ram.sv
hdl/pla_div.sv
hdl/pla_engine.sv
hdl/point_light_accumulate_unit.sv
hdl/pla_checker.sv
bench/pla_checker.sv
bench/tb.sv
